// File: rtl/dsfp_pkg.sv
// dsfp_pkg: frame constants, frame positions and the result type
// no dependencies; used by every file of the dust sensor frame parser
package dsfp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned RAW_W  = 16;
  localparam int unsigned DUST_W = 13;
  localparam int unsigned POS_W  = 4;

  localparam logic [BYTE_W-1:0] HDR_BYTE  = 8'hAA;
  localparam logic [BYTE_W-1:0] CMD_BYTE  = 8'hC0;
  localparam logic [BYTE_W-1:0] TAIL_BYTE = 8'hAB;

  localparam logic [POS_W-1:0] POS_HDR     = 4'd0;
  localparam logic [POS_W-1:0] POS_CMD     = 4'd1;
  localparam logic [POS_W-1:0] POS_FINE_LO = 4'd2;
  localparam logic [POS_W-1:0] POS_FINE_HI = 4'd3;
  localparam logic [POS_W-1:0] POS_CRS_LO  = 4'd4;
  localparam logic [POS_W-1:0] POS_CRS_HI  = 4'd5;
  localparam logic [POS_W-1:0] POS_EXTRA0  = 4'd6;
  localparam logic [POS_W-1:0] POS_EXTRA1  = 4'd7;
  localparam logic [POS_W-1:0] POS_SUM     = 4'd8;
  localparam logic [POS_W-1:0] POS_TAIL    = 4'd9;

  // x / 10 == (x * 52429) >> 19 for every 16-bit x
  localparam int unsigned     DIV10_MUL_W = 17;
  localparam int unsigned     DIV10_SHIFT = 19;
  localparam int unsigned     DIV10_PROD_W = RAW_W + DIV10_MUL_W;
  localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 17'd52429;

  typedef struct packed {
    logic              frame_good;
    logic [DUST_W-1:0] fine_dust;
    logic [DUST_W-1:0] coarse_dust;
  } result_t;

endpackage

// File: rtl/dsfp_if.sv
// dsfp_byte_if and dsfp_result_if: valid/ready channels of the frame parser
// depends on dsfp_pkg
interface dsfp_byte_if import dsfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface dsfp_result_if import dsfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              frame_good;
  logic [DUST_W-1:0] fine_dust;
  logic [DUST_W-1:0] coarse_dust;

  modport source (output valid, output frame_good, output fine_dust, output coarse_dust,
                  input ready);
  modport sink (input valid, input frame_good, input fine_dust, input coarse_dust,
                output ready);
endinterface

// File: rtl/dsfp_div10.sv
// dsfp_div10: registered divide by ten of a 16-bit reading
// reciprocal multiply; depends on dsfp_pkg
module dsfp_div10 import dsfp_pkg::*; (
  input  logic              clk,
  input  logic [RAW_W-1:0]  raw,
  output logic [DUST_W-1:0] quot
);

  logic [DIV10_PROD_W-1:0] prod;

  assign prod = {{DIV10_MUL_W{1'b0}}, raw} * {{RAW_W{1'b0}}, DIV10_MUL};

  always_ff @(posedge clk) begin
    quot <= prod[DIV10_SHIFT +: DUST_W];
  end

endmodule

// File: rtl/dsfp_parser.sv
// dsfp_parser: frame position tracking, checksum and result building
// depends on dsfp_pkg and dsfp_div10
module dsfp_parser import dsfp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              emit,
  output result_t           res
);

  logic [POS_W-1:0]  position;
  logic [POS_W-1:0]  position_next;
  logic [BYTE_W-1:0] sum_acc;
  logic [BYTE_W-1:0] sum_acc_next;
  logic              sum_matched;
  logic              sum_matched_next;
  logic [RAW_W-1:0]  fine_raw;
  logic [RAW_W-1:0]  fine_raw_next;
  logic [RAW_W-1:0]  coarse_raw;
  logic [RAW_W-1:0]  coarse_raw_next;
  logic [DUST_W-1:0] fine_q;
  logic [DUST_W-1:0] coarse_q;
  logic [POS_W-1:0]  pos;

  // quotients settle several transactions before the tail byte can arrive
  dsfp_div10 u_div_fine (.clk(clk), .raw(fine_raw), .quot(fine_q));
  dsfp_div10 u_div_coarse (.clk(clk), .raw(coarse_raw), .quot(coarse_q));

  always_comb begin
    pos              = (position > POS_TAIL) ? POS_HDR : position;
    position_next    = pos + POS_W'(1);
    sum_acc_next     = sum_acc;
    sum_matched_next = sum_matched;
    fine_raw_next    = fine_raw;
    coarse_raw_next  = coarse_raw;
    emit             = 1'b0;
    res              = '0;
    case (pos)
      POS_HDR: begin
        if (rx_byte != HDR_BYTE) begin
          emit = 1'b1;
        end
      end
      POS_CMD: begin
        if (rx_byte != CMD_BYTE) begin
          emit = 1'b1;
        end
      end
      POS_FINE_LO: begin
        fine_raw_next = {{(RAW_W-BYTE_W){1'b0}}, rx_byte};
        sum_acc_next  = rx_byte;
      end
      POS_FINE_HI: begin
        fine_raw_next = {rx_byte, fine_raw[BYTE_W-1:0]};
        sum_acc_next  = sum_acc + rx_byte;
      end
      POS_CRS_LO: begin
        coarse_raw_next = {{(RAW_W-BYTE_W){1'b0}}, rx_byte};
        sum_acc_next    = sum_acc + rx_byte;
      end
      POS_CRS_HI: begin
        coarse_raw_next = {rx_byte, coarse_raw[BYTE_W-1:0]};
        sum_acc_next    = sum_acc + rx_byte;
      end
      POS_EXTRA0, POS_EXTRA1: begin
        sum_acc_next = sum_acc + rx_byte;
      end
      POS_SUM: begin
        if (rx_byte != sum_acc) begin
          emit = 1'b1;
        end else begin
          sum_matched_next = 1'b1;
        end
      end
      default: begin
        position_next = POS_HDR;
        if (rx_byte != TAIL_BYTE) begin
          emit = 1'b1;
        end else if (sum_matched) begin
          emit            = 1'b1;
          res.frame_good  = 1'b1;
          res.fine_dust   = fine_q;
          res.coarse_dust = coarse_q;
        end
      end
    endcase
    // rejection or frame end restarts the parser
    if (emit || position_next == POS_HDR) begin
      position_next    = POS_HDR;
      sum_acc_next     = '0;
      sum_matched_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= POS_HDR;
      sum_acc     <= '0;
      sum_matched <= 1'b0;
      fine_raw    <= '0;
      coarse_raw  <= '0;
    end else if (accept) begin
      position    <= position_next;
      sum_acc     <= sum_acc_next;
      sum_matched <= sum_matched_next;
      fine_raw    <= fine_raw_next;
      coarse_raw  <= coarse_raw_next;
    end
  end

endmodule

// File: rtl/dsfp_out_buf.sv
// dsfp_out_buf: two-entry result buffer between parser and result channel
// depends on dsfp_pkg
module dsfp_out_buf import dsfp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    has_room,
  output logic    valid,
  input  logic    ready,
  output result_t data
);

  result_t    ent [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign has_room = (count != 2'd2);
  assign valid    = (count != 2'd0);
  assign data     = ent[rd_ptr];
  assign pop      = valid && ready;

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: rtl/dust_sensor_frame_parser.sv
// channel   direction  payload
// rx        in         rx_byte (8 bits)
// frame     out        frame_good (1), fine_dust (13), coarse_dust (13)
//
// one byte per cycle while the result buffer has room; each byte is settled in the cycle it is accepted
// the byte that ends or rejects a frame pushes its result into the buffer, which registers it for frame
// two-entry result buffer: rx stalls only while both entries wait on frame
// rst is synchronous and returns the parser to the header position
// top level of the dust sensor frame parser; depends on dsfp_pkg, dsfp_if,
// dsfp_parser, dsfp_out_buf
module dust_sensor_frame_parser import dsfp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  dsfp_byte_if.sink    rx,
  dsfp_result_if.source frame
);

  logic    accept;
  logic    emit;
  logic    has_room;
  result_t res;
  result_t out_data;

  assign rx.ready = has_room;
  assign accept   = rx.valid && has_room;

  dsfp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx.rx_byte),
    .emit    (emit),
    .res     (res)
  );

  dsfp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && emit),
    .push_data (res),
    .has_room  (has_room),
    .valid     (frame.valid),
    .ready     (frame.ready),
    .data      (out_data)
  );

  assign frame.frame_good  = out_data.frame_good;
  assign frame.fine_dust   = out_data.fine_dust;
  assign frame.coarse_dust = out_data.coarse_dust;

endmodule

// File: tb/tb_dust_sensor_frame_parser.sv
// tb_dust_sensor_frame_parser: self-checking testbench for the dust sensor frame parser
// depends on dsfp_pkg, dsfp_if and dust_sensor_frame_parser; runs a directed table,
// then random frames, with a local frame predictor and random stalls on both channels
module tb_dust_sensor_frame_parser;
  import dsfp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_NO_RESULT,
    ROW_RESULT
  } row_kind_t;

  typedef struct {
    logic [BYTE_W-1:0] rx_byte;
    row_kind_t         kind;
    result_t           res;
  } dir_row_t;

  localparam result_t NO_RES    = '0;
  localparam result_t BAD_RES   = '0;
  localparam result_t MAX_RES   = '{1'b1, 13'd6553, 13'd6553};
  localparam int      DIR_ROWS  = 24;
  localparam int      RAND_ITEMS = 1950;
  localparam int      HOLD_CYCLES = 60;

  logic clk;
  logic rst;

  dsfp_byte_if   rx_ch ();
  dsfp_result_if frame_ch ();

  dust_sensor_frame_parser dut (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx_ch),
    .frame (frame_ch)
  );

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{8'h00,     ROW_RESULT,    BAD_RES},
    '{8'hFF,     ROW_RESULT,    BAD_RES},
    '{HDR_BYTE,  ROW_NO_RESULT, NO_RES},
    // header byte in the command slot is dropped, not taken as a new header
    '{HDR_BYTE,  ROW_RESULT,    BAD_RES},
    '{CMD_BYTE,  ROW_RESULT,    BAD_RES},
    '{HDR_BYTE,  ROW_NO_RESULT, NO_RES},
    '{CMD_BYTE,  ROW_NO_RESULT, NO_RES},
    '{8'hFF,     ROW_NO_RESULT, NO_RES},
    '{8'hFF,     ROW_NO_RESULT, NO_RES},
    '{8'hFF,     ROW_NO_RESULT, NO_RES},
    '{8'hFF,     ROW_NO_RESULT, NO_RES},
    '{8'hFF,     ROW_NO_RESULT, NO_RES},
    '{8'hFF,     ROW_NO_RESULT, NO_RES},
    '{8'hFA,     ROW_NO_RESULT, NO_RES},
    '{TAIL_BYTE, ROW_RESULT,    MAX_RES},
    '{HDR_BYTE,  ROW_PREDICT,   NO_RES},
    '{CMD_BYTE,  ROW_PREDICT,   NO_RES},
    '{8'h12,     ROW_PREDICT,   NO_RES},
    '{8'h34,     ROW_PREDICT,   NO_RES},
    '{8'h56,     ROW_PREDICT,   NO_RES},
    '{8'h78,     ROW_PREDICT,   NO_RES},
    '{8'h9A,     ROW_PREDICT,   NO_RES},
    '{8'hBC,     ROW_PREDICT,   NO_RES},
    // checksum off by one
    '{8'h6B,     ROW_PREDICT,   NO_RES}
  };

  logic [POS_W-1:0]  frame_pos  = POS_HDR;
  logic [RAW_W-1:0]  fine_raw   = '0;
  logic [RAW_W-1:0]  coarse_raw = '0;
  logic [BYTE_W-1:0] csum_acc   = '0;
  logic              csum_ok    = 1'b0;

  result_t parsed_frames_q [$];
  int      mismatches = 0;
  int      bytes_fed  = 0;
  bit      quiet_run  = 1'b0;
  int      hold_left  = 0;
  int      frame_cyc  = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("dust_sensor_frame_parser test failed");
    $finish;
  end

  function automatic void parse_rx_byte(input logic [BYTE_W-1:0] b, output bit has_res,
                                        output result_t res);
    logic [POS_W-1:0] p;
    p = (frame_pos > POS_TAIL) ? POS_HDR : frame_pos;
    has_res = 1'b0;
    res = '0;
    frame_pos = p + 1'b1;
    case (p)
      POS_HDR: has_res = (b != HDR_BYTE);
      POS_CMD: has_res = (b != CMD_BYTE);
      POS_FINE_LO: begin
        fine_raw = {8'h00, b};
        csum_acc = b;
      end
      POS_FINE_HI: begin
        fine_raw[15:8] = b;
        csum_acc = csum_acc + b;
      end
      POS_CRS_LO: begin
        coarse_raw = {8'h00, b};
        csum_acc = csum_acc + b;
      end
      POS_CRS_HI: begin
        coarse_raw[15:8] = b;
        csum_acc = csum_acc + b;
      end
      POS_EXTRA0, POS_EXTRA1: csum_acc = csum_acc + b;
      POS_SUM: begin
        if (b != csum_acc) has_res = 1'b1;
        else csum_ok = 1'b1;
      end
      default: begin
        if (b != TAIL_BYTE) begin
          has_res = 1'b1;
        end else if (csum_ok) begin
          has_res = 1'b1;
          res.frame_good  = 1'b1;
          res.fine_dust   = DUST_W'(fine_raw / 16'd10);
          res.coarse_dust = DUST_W'(coarse_raw / 16'd10);
        end
      end
    endcase
    if (has_res || p == POS_TAIL) begin
      frame_pos = POS_HDR;
      csum_acc = '0;
      csum_ok = 1'b0;
    end
  endfunction

  task automatic feed_byte(input logic [BYTE_W-1:0] b, input row_kind_t kind,
                           input result_t typed);
    bit      has_res;
    result_t res;
    while (!quiet_run && $urandom_range(0, 99) < 19) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    bytes_fed++;
    parse_rx_byte(b, has_res, res);
    case (kind)
      ROW_PREDICT:   if (has_res) parsed_frames_q.push_back(res);
      ROW_RESULT:    parsed_frames_q.push_back(typed);
      ROW_NO_RESULT: ;
      default:       ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      frame_ch.ready <= 1'b0;
    end else begin
      if (frame_ch.valid && frame_ch.ready) begin
        if (parsed_frames_q.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, got %0d/%0d/%0d", $time,
                   frame_ch.frame_good, frame_ch.fine_dust, frame_ch.coarse_dust);
          mismatches++;
        end else begin
          if (frame_ch.frame_good !== parsed_frames_q[0].frame_good) begin
            $display("%0t: frame_good expected %0d, got %0d", $time,
                     parsed_frames_q[0].frame_good, frame_ch.frame_good);
            mismatches++;
          end
          if (frame_ch.fine_dust !== parsed_frames_q[0].fine_dust) begin
            $display("%0t: fine_dust expected %0d, got %0d", $time,
                     parsed_frames_q[0].fine_dust, frame_ch.fine_dust);
            mismatches++;
          end
          if (frame_ch.coarse_dust !== parsed_frames_q[0].coarse_dust) begin
            $display("%0t: coarse_dust expected %0d, got %0d", $time,
                     parsed_frames_q[0].coarse_dust, frame_ch.coarse_dust);
            mismatches++;
          end
          void'(parsed_frames_q.pop_front());
        end
      end
      frame_cyc++;
      // long hold-off so the result buffer fills and rx backs up
      if (hold_left > 0) begin
        hold_left--;
        frame_ch.ready <= 1'b0;
      end else if (frame_cyc % 1500 == 700) begin
        hold_left = HOLD_CYCLES;
        frame_ch.ready <= 1'b0;
      end else begin
        frame_ch.ready <= quiet_run || ($urandom_range(0, 99) >= 19);
      end
    end
  end

  initial begin
    logic [BYTE_W-1:0] fr [10];
    logic [RAW_W-1:0]  reading;
    int                pick;
    int                last;
    int                cut;

    rst           = 1'b1;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) feed_byte(dir_rows[i].rx_byte, dir_rows[i].kind, dir_rows[i].res);

    while (bytes_fed < DIR_ROWS + RAND_ITEMS) begin
      quiet_run = (bytes_fed >= 800 && bytes_fed < 1100);
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        fr[0] = HDR_BYTE;
        fr[1] = CMD_BYTE;
        for (int r = 0; r < 2; r++) begin
          case ($urandom_range(0, 9))
            0:       reading = 16'hFFFF;
            1:       reading = 16'h0000;
            default: reading = RAW_W'($urandom_range(0, 65535));
          endcase
          fr[2 + 2 * r] = reading[7:0];
          fr[3 + 2 * r] = reading[15:8];
        end
        fr[6] = BYTE_W'($urandom_range(0, 255));
        fr[7] = BYTE_W'($urandom_range(0, 255));
        fr[8] = fr[2] + fr[3] + fr[4] + fr[5] + fr[6] + fr[7];
        fr[9] = TAIL_BYTE;
        last = 9;
        if (pick >= 60) begin
          case ($urandom_range(0, 3))
            0:       cut = int'(POS_HDR);
            1:       cut = int'(POS_CMD);
            2:       cut = int'(POS_SUM);
            default: cut = int'(POS_TAIL);
          endcase
          fr[cut] = fr[cut] ^ BYTE_W'($urandom_range(1, 255));
          last = cut;
        end
        for (int k = 0; k <= last; k++) feed_byte(fr[k], ROW_PREDICT, NO_RES);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 3) == 0) feed_byte(HDR_BYTE, ROW_PREDICT, NO_RES);
          else feed_byte(BYTE_W'($urandom_range(0, 255)), ROW_PREDICT, NO_RES);
        end
      end
    end
    quiet_run = 1'b0;
    rx_ch.valid <= 1'b0;

    while (parsed_frames_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (parsed_frames_q.size() != 0) mismatches++;

    if (mismatches == 0) begin
      $display("dust_sensor_frame_parser test passed");
    end else begin
      $display("dust_sensor_frame_parser test failed");
    end
    $finish;
  end

endmodule
